>>> hdl/ecf_pkg.sv
`timescale 1ns / 1ps

package ecf_pkg;

  // Fixed widths of the register file and srtt input
  localparam int RTT_W    = 32;
  localparam int GAIN_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [RTT_W-1:0]  RTT_VIRT_MIN_RESET = 32'd25000;
  localparam logic [GAIN_W-1:0] GAIN_SHIFT_RESET   = 4'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_VIRT_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT   = 1'b1;

  typedef enum logic [2:0] {
    STAT_IDLE      = 3'd0,
    STAT_NO_MARKS  = 3'd1,
    STAT_ADVANCED  = 3'd2,
    STAT_UPDATED   = 3'd3,
    STAT_VIOLATION = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RTT,
    ST_EVAL,
    ST_FLOAD,
    ST_FDIV,
    ST_MUL,
    ST_NLOAD,
    ST_NDIV,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic upd_rtt;
    logic eval;
    logic div_start;
    logic div_norm;
    logic ewma;
    logic mul;
    logic norm_store;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_ewma;
    logic div_done;
  } sts_t;

endpackage

>>> hdl/ecn_ce_fraction_ewma.sv
`timescale 1ns / 1ps
// Each ack runs through capture, evaluation, multiply and normalisation; when the
//   CE fraction is computed, the shared restoring divider runs for it as well and
//   gives one quotient bit per cycle, as it does for the normalisation.
// A new ack is accepted only once the previous one has reached the result register.
// Reset (rst_ni low, async): registers back to 25000 us and shift 4, virtual RTT 25000,
//   counters, time and weight cleared, both channels empty.
`default_nettype none

module ecn_ce_fraction_ewma import ecf_pkg::*; #(
  parameter int COUNT_BITS = 40,
  parameter int TIME_BITS  = 48,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [RTT_W-1:0]      cfg_data_i,
  // ack transaction in
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  l4s_valid_i,
  input  wire logic                  rtt_sample_i,
  input  wire logic [RTT_W-1:0]      srtt_us_i,
  input  wire logic [TIME_BITS-1:0]  ack_time_us_i,
  input  wire logic [COUNT_BITS-1:0] ect1_count_i,
  input  wire logic [COUNT_BITS-1:0] ce_count_i,
  // result transaction out
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [2:0]            status_o,
  output      logic [FRAC_BITS:0]    weight_o,
  output      logic [FRAC_BITS+3:0]  normalized_weight_o,
  output      logic                  report_o,
  output      logic [COUNT_BITS-1:0] new_ect1_o,
  output      logic [COUNT_BITS-1:0] new_ce_o
);

  // The controller walks each transaction through: capture, virtual RTT update,
  // interval/backward-count evaluation, optional CE fraction division and EWMA step,
  // weight*srtt multiply, normalisation division, result hand-off.
  // The result sits in its own register, so a new ack is taken while the
  // previous result still waits on out_ready_i.
  cmd_t cmd;
  sts_t sts;

  ecf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath holds the connection state, the shared divider and the multiplier.
  // Normalisation saturates by a single compare of the product's upper bits
  // against the virtual RTT (zero virtual RTT divides by one).
  ecf_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .l4s_valid_i         (l4s_valid_i),
    .rtt_sample_i        (rtt_sample_i),
    .srtt_us_i           (srtt_us_i),
    .ack_time_us_i       (ack_time_us_i),
    .ect1_count_i        (ect1_count_i),
    .ce_count_i          (ce_count_i),
    .status_o            (status_o),
    .weight_o            (weight_o),
    .normalized_weight_o (normalized_weight_o),
    .report_o            (report_o),
    .new_ect1_o          (new_ect1_o),
    .new_ce_o            (new_ce_o)
  );

  // One transaction in flight: no second acceptance straight after the first
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction is in progress");

  // Reporting only goes with a weight update
  a_report_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_o |-> status_o == STAT_UPDATED)
    else $error("report without weight update");

  // Deltas are zero unless reported
  a_delta_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_o |-> new_ce_o == '0 && new_ect1_o == '0)
    else $error("deltas present without report");

  // The EWMA never exceeds 1.0
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weight_o <= {1'b1, {FRAC_BITS{1'b0}}})
    else $error("weight above 1.0");

endmodule

`default_nettype wire

>>> hdl/ecf_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Expects rem_init < divisor.
module ecf_div #(
  parameter int DW = 41,
  parameter int QW = 20,
  parameter int CW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_init_i,
  input  logic [QW-1:0] num_low_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [CW-1:0] steps_i,
  output logic [QW-1:0] quot_o,
  output logic          done_o
);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] num_q, num_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   trial;
  logic          fits;

  assign trial  = {rem_q, num_q[QW-1]};
  assign fits   = trial >= {1'b0, div_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      num_d  = num_low_i;
      quot_d = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q - CW'(1);
        rem_d  = fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
        num_d  = {num_q[QW-2:0], 1'b0};
        quot_d = {quot_q[QW-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

endmodule

>>> hdl/ecf_datapath.sv
`timescale 1ns / 1ps

module ecf_datapath import ecf_pkg::*; #(
  parameter int COUNT_BITS = 40,
  parameter int TIME_BITS  = 48,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [RTT_W-1:0]       cfg_data_i,
  input  logic                   l4s_valid_i,
  input  logic                   rtt_sample_i,
  input  logic [RTT_W-1:0]       srtt_us_i,
  input  logic [TIME_BITS-1:0]   ack_time_us_i,
  input  logic [COUNT_BITS-1:0]  ect1_count_i,
  input  logic [COUNT_BITS-1:0]  ce_count_i,
  output logic [2:0]             status_o,
  output logic [FRAC_BITS:0]     weight_o,
  output logic [FRAC_BITS+3:0]   normalized_weight_o,
  output logic                   report_o,
  output logic [COUNT_BITS-1:0]  new_ect1_o,
  output logic [COUNT_BITS-1:0]  new_ce_o
);

  localparam int WW = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 4;
  localparam int PW = WW + RTT_W;
  localparam int HW = PW - NW;
  localparam int SW = COUNT_BITS + 1;
  localparam int DW = (SW > RTT_W) ? SW : RTT_W;
  localparam int CW = $clog2(NW + 1);
  localparam logic [WW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [RTT_W-1:0]  rtt_min_q;
  logic [GAIN_W-1:0] gain_q;

  // captured transaction
  logic                  valid_q, sample_q;
  logic [RTT_W-1:0]      srtt_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [COUNT_BITS-1:0] ect1_q, ce_q;

  // connection state
  logic [RTT_W-1:0]      rtt_virt_q;
  logic [TIME_BITS-1:0]  last_time_q;
  logic [COUNT_BITS-1:0] last_ect1_q, last_ce_q;
  logic [WW-1:0]         weight_q;

  // working registers
  status_e               status_q;
  logic                  report_q;
  logic [COUNT_BITS-1:0] n_ce_q, n_ect1_q;
  logic [PW-1:0]         prod_q;
  logic [NW-1:0]         norm_q;

  // result registers
  status_e               out_status_q;
  logic [WW-1:0]         out_weight_q;
  logic [NW-1:0]         out_norm_q;
  logic                  out_report_q;
  logic [COUNT_BITS-1:0] out_d_ect1_q, out_d_ce_q;

  // evaluation
  logic                  first_ce, due, back, no_delta, commit, need_ewma;
  logic [TIME_BITS-1:0]  elapsed;
  logic [COUNT_BITS-1:0] d_ce, d_ect1;
  status_e               eval_status;

  always_comb begin
    first_ce  = (ce_q != '0) && (last_ce_q == '0);
    elapsed   = now_q - last_time_q;
    due       = (elapsed >= TIME_BITS'(rtt_virt_q)) || first_ce;
    back      = (ce_q < last_ce_q) || (ect1_q < last_ect1_q);
    d_ce      = ce_q - last_ce_q;
    d_ect1    = ect1_q - last_ect1_q;
    no_delta  = (d_ce == '0) && (d_ect1 == '0);
    commit    = 1'b0;
    need_ewma = 1'b0;
    if (!valid_q || !due) begin
      eval_status = STAT_IDLE;
    end else if (back) begin
      eval_status = STAT_VIOLATION;
    end else if (no_delta) begin
      eval_status = STAT_NO_MARKS;
    end else if (ce_q != '0) begin
      eval_status = STAT_UPDATED;
      commit      = 1'b1;
      need_ewma   = 1'b1;
    end else begin
      eval_status = STAT_ADVANCED;
      commit      = 1'b1;
    end
  end

  // shared divider: CE fraction, then normalisation
  logic [RTT_W-1:0] rtt_div;
  logic [HW-1:0]    prod_hi;
  logic [SW-1:0]    total;
  logic [DW-1:0]    div_rem_init, div_divisor;
  logic [NW-1:0]    div_num, div_quot;
  logic [CW-1:0]    div_steps;
  logic             div_done, norm_sat;

  assign rtt_div  = (rtt_virt_q == '0) ? RTT_W'(1) : rtt_virt_q;
  assign prod_hi  = prod_q[PW-1:NW];
  assign total    = SW'(n_ce_q) + SW'(n_ect1_q);
  assign norm_sat = DW'(prod_hi) >= DW'(rtt_div);

  assign div_rem_init = cmd_i.div_norm ? DW'(prod_hi) : DW'(n_ce_q);
  assign div_divisor  = cmd_i.div_norm ? DW'(rtt_div) : DW'(total);
  assign div_num      = cmd_i.div_norm ? prod_q[NW-1:0] : '0;
  assign div_steps    = cmd_i.div_norm ? CW'(NW) : CW'(FRAC_BITS);

  ecf_div #(
    .DW (DW),
    .QW (NW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem_init),
    .num_low_i  (div_num),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // EWMA step, truncated toward the old weight
  logic [WW-1:0] frac, w_next;

  always_comb begin
    frac = (n_ect1_q == '0) ? ONE_Q : WW'(div_quot[FRAC_BITS-1:0]);
    if (frac >= weight_q) begin
      w_next = weight_q + ((frac - weight_q) >> gain_q);
    end else begin
      w_next = weight_q - ((weight_q - frac) >> gain_q);
    end
  end

  assign sts_o.need_ewma = need_ewma;
  assign sts_o.div_done  = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_min_q   <= RTT_VIRT_MIN_RESET;
      gain_q      <= GAIN_SHIFT_RESET;
      rtt_virt_q  <= RTT_VIRT_MIN_RESET;
      last_time_q <= '0;
      last_ect1_q <= '0;
      last_ce_q   <= '0;
      weight_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RTT_VIRT_MIN: rtt_min_q <= cfg_data_i;
          CFG_GAIN_SHIFT:   gain_q    <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.upd_rtt && valid_q && sample_q) begin
        rtt_virt_q <= (srtt_q > rtt_min_q) ? srtt_q : rtt_min_q;
      end
      if (cmd_i.eval) begin
        if (commit) begin
          last_time_q <= now_q;
          last_ect1_q <= ect1_q;
          last_ce_q   <= ce_q;
        end
        if (need_ewma && first_ce) begin
          weight_q <= ONE_Q;
        end
      end
      if (cmd_i.ewma) begin
        weight_q <= w_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      valid_q  <= l4s_valid_i;
      sample_q <= rtt_sample_i;
      srtt_q   <= srtt_us_i;
      now_q    <= ack_time_us_i;
      ect1_q   <= ect1_count_i;
      ce_q     <= ce_count_i;
    end
    if (cmd_i.eval) begin
      status_q <= eval_status;
      report_q <= need_ewma && (d_ce != '0);
      n_ce_q   <= d_ce;
      n_ect1_q <= d_ect1;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(weight_q) * PW'(srtt_q);
    end
    if (cmd_i.norm_store) begin
      norm_q <= norm_sat ? {NW{1'b1}} : div_quot;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_weight_q <= weight_q;
      out_norm_q   <= norm_q;
      out_report_q <= report_q;
      out_d_ect1_q <= report_q ? n_ect1_q : '0;
      out_d_ce_q   <= report_q ? n_ce_q : '0;
    end
  end

  assign status_o            = out_status_q;
  assign weight_o            = out_weight_q;
  assign normalized_weight_o = out_norm_q;
  assign report_o            = out_report_q;
  assign new_ect1_o          = out_d_ect1_q;
  assign new_ce_o            = out_d_ce_q;

endmodule

>>> hdl/ecf_ctrl.sv
`timescale 1ns / 1ps

module ecf_ctrl import ecf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RTT;
        end
      end
      ST_RTT: begin
        cmd_o.upd_rtt = 1'b1;
        state_d       = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_ewma ? ST_FLOAD : ST_MUL;
      end
      ST_FLOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_FDIV;
      end
      ST_FDIV: begin
        if (sts_i.div_done) begin
          cmd_o.ewma = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_NLOAD;
      end
      ST_NLOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_norm  = 1'b1;
        state_d         = ST_NDIV;
      end
      ST_NDIV: begin
        cmd_o.div_norm = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.norm_store = 1'b1;
          state_d          = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> verif/tb_ecn_ce_fraction_ewma.sv
`timescale 1ns / 1ps

// Testbench for the CE fraction EWMA tracker.
// Acks go in on a valid/ready channel. Each accepted transaction runs through a local
// model of the tracker, and the expected result is queued. A monitor compares every
// output transaction, field by field, with the oldest entry in that queue.
module tb_ecn_ce_fraction_ewma;
  import ecf_pkg::*;

  localparam int COUNT_BITS = 40;
  localparam int TIME_BITS  = 48;
  localparam int FRAC_BITS  = 16;

  localparam logic [FRAC_BITS:0]   WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+3:0] NORM_MAX   = '1;

  // The slowest correct run is about 850 acks, each spending its time in the block, in
  // sender gaps and in receiver stalls, plus one hold-off of HOLD_CYCLES; the limit
  // below leaves plenty of slack for that.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic                  l4s;
    logic                  sample;
    logic [RTT_W-1:0]      srtt;
    logic [TIME_BITS-1:0]  now;
    logic [COUNT_BITS-1:0] ect1;
    logic [COUNT_BITS-1:0] ce;
  } ack_t;

  typedef struct {
    status_e               status;
    logic [FRAC_BITS:0]    weight;
    logic [FRAC_BITS+3:0]  norm;
    logic                  report;
    logic [COUNT_BITS-1:0] d_ect1;
    logic [COUNT_BITS-1:0] d_ce;
  } ewma_result_t;

  // DUT connections. Every input has a known value from time zero.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_RTT_VIRT_MIN;
  logic [RTT_W-1:0]      cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  l4s_valid_i = 1'b0;
  logic                  rtt_sample_i = 1'b0;
  logic [RTT_W-1:0]      srtt_us_i = '0;
  logic [TIME_BITS-1:0]  ack_time_us_i = '0;
  logic [COUNT_BITS-1:0] ect1_count_i = '0;
  logic [COUNT_BITS-1:0] ce_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            status_o;
  logic [FRAC_BITS:0]    weight_o;
  logic [FRAC_BITS+3:0]  normalized_weight_o;
  logic                  report_o;
  logic [COUNT_BITS-1:0] new_ect1_o;
  logic [COUNT_BITS-1:0] new_ce_o;

  ecn_ce_fraction_ewma #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .l4s_valid_i        (l4s_valid_i),
    .rtt_sample_i       (rtt_sample_i),
    .srtt_us_i          (srtt_us_i),
    .ack_time_us_i      (ack_time_us_i),
    .ect1_count_i       (ect1_count_i),
    .ce_count_i         (ce_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .weight_o           (weight_o),
    .normalized_weight_o(normalized_weight_o),
    .report_o           (report_o),
    .new_ect1_o         (new_ect1_o),
    .new_ce_o           (new_ce_o)
  );

  // Local copy of the tracker: registers and connection state.
  logic [RTT_W-1:0]      p_rtt_min = RTT_VIRT_MIN_RESET;
  logic [GAIN_W-1:0]     p_gain = GAIN_SHIFT_RESET;
  logic [RTT_W-1:0]      p_rtt_virt = 32'd25000;
  logic [TIME_BITS-1:0]  p_last_time = '0;
  logic [COUNT_BITS-1:0] p_last_ect1 = '0;
  logic [COUNT_BITS-1:0] p_last_ce = '0;
  logic [FRAC_BITS:0]    p_weight = '0;

  // Running cumulative counts and clock of the simulated connection.
  logic [TIME_BITS-1:0]  acc_time;
  logic [COUNT_BITS-1:0] acc_ect1;
  logic [COUNT_BITS-1:0] acc_ce;

  ewma_result_t pending_results[$];

  int error_count = 0;
  int acks_sent = 0;
  int acks_ignored = 0;
  int results_checked = 0;
  int status_seen[5] = '{default: 0};
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Works out what one ack yields and moves the local state along with it.
  function automatic ewma_result_t predict_ack(ack_t a);
    ewma_result_t         r;
    logic                 first_ce;
    logic [TIME_BITS-1:0] elapsed;
    logic [COUNT_BITS:0]  n_ce;
    logic [COUNT_BITS:0]  n_ect1;
    logic [COUNT_BITS:0]  total;
    logic [63:0]          rem;
    logic [63:0]          quo;
    logic [63:0]          divisor;
    logic [63:0]          scaled;
    logic [FRAC_BITS:0]   frac;
    logic [FRAC_BITS:0]   w;
    r.status = STAT_IDLE;
    r.report = 1'b0;
    r.d_ect1 = '0;
    r.d_ce   = '0;
    if (a.l4s) begin
      first_ce = (a.ce != '0) && (p_last_ce == '0);
      if (a.sample) begin
        p_rtt_virt = (a.srtt > p_rtt_min) ? a.srtt : p_rtt_min;
      end
      elapsed = a.now - p_last_time;  // wraps with the ack clock
      if (elapsed >= p_rtt_virt || first_ce) begin
        if (a.ce < p_last_ce || a.ect1 < p_last_ect1) begin
          r.status = STAT_VIOLATION;
        end else begin
          n_ce   = {1'b0, a.ce - p_last_ce};
          n_ect1 = {1'b0, a.ect1 - p_last_ect1};
          total  = n_ce + n_ect1;
          if (total == '0) begin
            r.status = STAT_NO_MARKS;
          end else begin
            r.status = STAT_ADVANCED;
            if (a.ce != '0) begin
              if (first_ce) begin
                p_weight = WEIGHT_ONE;
              end
              // CE share in Q1.16, floor, by restoring long division
              if (n_ce >= total) begin
                frac = WEIGHT_ONE;
              end else begin
                rem = 64'(n_ce);
                quo = '0;
                for (int i = 0; i < FRAC_BITS; i++) begin
                  rem = rem << 1;
                  quo = quo << 1;
                  if (rem >= total) begin
                    rem = rem - total;
                    quo[0] = 1'b1;
                  end
                end
                frac = quo[FRAC_BITS:0];
              end
              w = p_weight;
              if (frac >= w) begin
                w = w + ((frac - w) >> p_gain);
              end else begin
                w = w - ((w - frac) >> p_gain);
              end
              p_weight = w;
              r.status = STAT_UPDATED;
              if (n_ce != '0) begin
                r.report = 1'b1;
                r.d_ect1 = n_ect1[COUNT_BITS-1:0];
                r.d_ce   = n_ce[COUNT_BITS-1:0];
              end
            end
            p_last_time = a.now;
            p_last_ect1 = a.ect1;
            p_last_ce   = a.ce;
          end
        end
      end
    end
    r.weight = p_weight;
    divisor  = (p_rtt_virt != '0) ? 64'(p_rtt_virt) : 64'd1;
    scaled   = (64'(p_weight) * 64'(a.srtt)) / divisor;
    r.norm   = (scaled > 64'(NORM_MAX)) ? NORM_MAX : scaled[FRAC_BITS+3:0];
    return r;
  endfunction

  function automatic ack_t make_ack(bit l4s, bit smp, logic [RTT_W-1:0] srtt,
                                    logic [TIME_BITS-1:0] t, logic [COUNT_BITS-1:0] e,
                                    logic [COUNT_BITS-1:0] c);
    ack_t a;
    a.l4s    = l4s;
    a.sample = smp;
    a.srtt   = srtt;
    a.now    = t;
    a.ect1   = e;
    a.ce     = c;
    return a;
  endfunction

  // Offers one ack (after a random idle gap) and predicts its result once it is taken.
  task automatic send_ack(ack_t a);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      gap++;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    l4s_valid_i   <= a.l4s;
    rtt_sample_i  <= a.sample;
    srtt_us_i     <= a.srtt;
    ack_time_us_i <= a.now;
    ect1_count_i  <= a.ect1;
    ce_count_i    <= a.ce;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_ack(a));
    acks_sent++;
    if (!a.l4s) acks_ignored++;
  endtask

  // Drops valid and waits for all outstanding results, so the block is idle after this.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RTT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_RTT_VIRT_MIN) p_rtt_min = data;
    else p_gain = data[GAIN_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Result monitor: sampled on the rising edge, in arrival order.
  always @(posedge clk_i) begin
    ewma_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_o <= 3'd4) status_seen[status_o]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(status_o), 64'd0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o != want.status) begin
          report_mismatch("status", 64'(status_o), 64'(want.status));
        end
        if (weight_o != want.weight) begin
          report_mismatch("weight", 64'(weight_o), 64'(want.weight));
        end
        if (normalized_weight_o != want.norm) begin
          report_mismatch("normalized_weight", 64'(normalized_weight_o), 64'(want.norm));
        end
        if (report_o != want.report) begin
          report_mismatch("report", 64'(report_o), 64'(want.report));
        end
        if (new_ect1_o != want.d_ect1) begin
          report_mismatch("new_ect1", 64'(new_ect1_o), 64'(want.d_ect1));
        end
        if (new_ce_o != want.d_ce) begin
          report_mismatch("new_ce", 64'(new_ce_o), 64'(want.d_ce));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request, counted here.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Next ack of the simulated connection: mostly well formed, some with counts
  // running backwards, some noise.
  task automatic next_connection_ack(output ack_t a);
    logic [63:0]      span;
    logic [63:0]      step;
    logic [RTT_W-1:0] srtt;
    bit               smp;
    int               kind;
    kind = $urandom_range(99);
    if (acc_ect1 < p_last_ect1) acc_ect1 = p_last_ect1;
    if (acc_ce < p_last_ce) acc_ce = p_last_ce;
    span = (p_rtt_virt == '0) ? 64'd1 : 64'(p_rtt_virt);
    case ($urandom_range(3))
      0:       step = 64'($urandom_range(32'(span >> 1)));
      1, 2:    step = span + 64'($urandom_range(32'(span >> 2)));
      default: step = span + span + 64'($urandom_range(32'(span)));
    endcase
    smp = ($urandom_range(9) < 3);
    if (smp) begin
      srtt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4000);
    end else begin
      srtt = (span > 64'h7FFF_FFFF) ? $urandom : $urandom_range(32'(span << 1));
    end
    if (kind < 75) begin
      acc_time = acc_time + TIME_BITS'(step);
      if ($urandom_range(9) != 0) begin
        acc_ect1 = acc_ect1 + $urandom_range(30);
        if ($urandom_range(2) == 0) acc_ce = acc_ce + $urandom_range(10);
        if ($urandom_range(19) == 0) acc_ce = acc_ce + $urandom_range(60);
      end
      a = make_ack(1'b1, smp, srtt, acc_time, acc_ect1, acc_ce);
    end else if (kind < 88 && (p_last_ce != '0 || p_last_ect1 != '0)) begin
      // counts running backwards, elapsed interval so the check is reached
      acc_time = acc_time + TIME_BITS'(span);
      if (p_last_ce != '0 && $urandom_range(1) == 0) begin
        a = make_ack(1'b1, smp, srtt, acc_time, acc_ect1 + $urandom_range(5),
                     p_last_ce - 1 - $urandom_range(3) % p_last_ce);
      end else if (p_last_ect1 != '0) begin
        a = make_ack(1'b1, smp, srtt, acc_time, p_last_ect1 - 1, acc_ce);
      end else begin
        a = make_ack(1'b1, smp, srtt, acc_time, acc_ect1, p_last_ce - 1);
      end
    end else if ($urandom_range(1) == 0) begin
      // ignored ack: anything goes
      a = make_ack(1'b0, 1'($urandom_range(1)), $urandom,
                   TIME_BITS'({$urandom, $urandom}),
                   COUNT_BITS'({$urandom, $urandom}), COUNT_BITS'({$urandom, $urandom}));
    end else begin
      // random time and sample, counts moved forward by a random amount up to 2^20
      a = make_ack(1'b1, 1'($urandom_range(1)), $urandom,
                   TIME_BITS'({$urandom, $urandom}),
                   p_last_ect1 + $urandom_range(1 << 20), p_last_ce + $urandom_range(1 << 20));
    end
  endtask

  // Walks through the status codes, the first CE mark, saturation and wide deltas on an ack that is not due.
  task automatic test_status_paths();
    send_ack(make_ack(1'b0, 1'b1, '1, '1, '1, '1));     // ignored ack, all ones
    send_ack(make_ack(1'b1, 1'b0, 32'd20000, 48'd10, 40'd5, 40'd0));     // interval not due
    send_ack(make_ack(1'b1, 1'b0, 32'd20000, 48'd30000, 40'd10, 40'd0)); // advanced, no CE
    send_ack(make_ack(1'b1, 1'b0, 32'd25000, 48'd60000, 40'd10, 40'd0)); // no new marks
    send_ack(make_ack(1'b1, 1'b0, 32'd25000, 48'd60010, 40'd12, 40'd4)); // first CE at once
    // not due: counts and srtt all ones, scaled weight saturates
    send_ack(make_ack(1'b1, 1'b0, '1, 48'd60020, '1, '1));
    // RTT sample above the minimum, deltas wide enough to set the top count bit, interval not yet due
    send_ack(make_ack(1'b1, 1'b1, 32'd40000, 48'd100000,
                      p_last_ect1 + (40'd1 << 39) + 40'd7, p_last_ce + (40'd1 << 39) + 40'd3));
    // CE count backwards; the RTT sample still takes effect
    send_ack(make_ack(1'b1, 1'b1, 32'd30000, 48'd200000, p_last_ect1, p_last_ce - 1));
    send_ack(make_ack(1'b1, 1'b0, 32'd30000, 48'd300000, p_last_ect1 + 100, p_last_ce));
    send_ack(make_ack(1'b1, 1'b0, 32'd60000, 48'd400000, p_last_ect1, p_last_ce));
    wait_idle();
  endtask

  // Minimum of zero with a zero srtt sample: the scaling divides by one.
  task automatic test_zero_virtual_rtt();
    write_reg(CFG_RTT_VIRT_MIN, 32'd0);
    write_reg(CFG_GAIN_SHIFT, 32'd0);
    send_ack(make_ack(1'b1, 1'b1, 32'd0, p_last_time + 1, p_last_ect1 + 3, p_last_ce + 1));
    send_ack(make_ack(1'b1, 1'b0, '1, p_last_time, p_last_ect1, p_last_ce));
    send_ack(make_ack(1'b1, 1'b0, 32'd1, p_last_time + 2, p_last_ect1, p_last_ce + 5));
    wait_idle();
  endtask

  // Largest minimum and largest shift.
  task automatic test_register_extremes();
    write_reg(CFG_GAIN_SHIFT, 32'd15);
    write_reg(CFG_RTT_VIRT_MIN, 32'hFFFF_FFFF);
    send_ack(make_ack(1'b1, 1'b1, 32'd5, p_last_time + 10, p_last_ect1 + 9, p_last_ce + 1));
    send_ack(make_ack(1'b1, 1'b0, 32'hFFFF_FFFF, p_last_time + 48'hFFFF_FFFF,
                      p_last_ect1 + 50, p_last_ce + 1));
    send_ack(make_ack(1'b1, 1'b0, 32'h8000_0000, p_last_time + 3, p_last_ect1 + 2, p_last_ce));
    wait_idle();
  endtask

  // Ack clock wrapping past all ones.
  task automatic test_time_wrap();
    write_reg(CFG_RTT_VIRT_MIN, 32'd1000);
    write_reg(CFG_GAIN_SHIFT, 32'd4);
    send_ack(make_ack(1'b1, 1'b1, 32'd0, 48'hFFFF_FFFF_FF38, p_last_ect1 + 7, p_last_ce + 2));
    send_ack(make_ack(1'b1, 1'b0, 32'd1500, 48'd900, p_last_ect1 + 1, p_last_ce + 1));
    send_ack(make_ack(1'b1, 1'b0, 32'd1500, 48'd950, p_last_ect1 + 4, p_last_ce + 4));
    wait_idle();
  endtask

  task automatic test_random_traffic(int n_valid, int src_pct, int snk_pct,
                                     logic [RTT_W-1:0] rmin, logic [GAIN_W-1:0] gain);
    ack_t a;
    int   counted;
    write_reg(CFG_RTT_VIRT_MIN, rmin);
    write_reg(CFG_GAIN_SHIFT, RTT_W'(gain));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    acc_time = p_last_time;
    counted  = 0;
    while (counted < n_valid) begin
      next_connection_ack(a);
      send_ack(a);
      if (a.l4s) counted++;
    end
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while acks keep coming, so the input backs up.
  task automatic test_receiver_hold();
    ack_t a;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    acc_time = p_last_time;
    @(posedge clk_i);
    hold_request = 1'b1;
    repeat (16) begin
      next_connection_ack(a);
      send_ack(a);
    end
    wait_idle();
  endtask

  initial begin
    acc_time = '0;
    acc_ect1 = '0;
    acc_ce   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_status_paths();
    test_zero_virtual_rtt();
    test_register_extremes();
    test_time_wrap();
    test_random_traffic(250, 24, 64, $urandom_range(3000, 1), GAIN_W'($urandom_range(15)));
    test_random_traffic(250, 64, 24, $urandom_range(3000, 1), GAIN_W'($urandom_range(15)));
    test_receiver_hold();
    test_random_traffic(265, 0, 0, 32'd25000, 4'd4);

    // let any stray output show up before closing
    repeat (64) @(posedge clk_i);
    $display("run: %0d acks sent (%0d ignored), %0d results checked, %0d mismatches",
             acks_sent, acks_ignored, results_checked, error_count);
    $display("statuses: idle %0d, no marks %0d, advanced %0d, updated %0d, violation %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
